// ===== src/psyn_pkg.sv =====
// Shared constants, codes and command/status types of the polyphonic synth core.
package psyn_pkg;

  localparam int VOICES_DEF      = 8;
  localparam int WAVE_POINTS_DEF = 256;
  localparam int SAMPLE_RATE_DEF = 48000;

  localparam int ACTION_W    = 2;
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 16;
  localparam int SAMPLE_W    = 16;
  localparam int COUNT_OUT_W = 4;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int ENV_W       = 3;

  localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd1;

  localparam logic [MODE_W-1:0] MODE_PIANO   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EPIANO  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STRINGS = 2'd2;

  localparam logic [ENV_W-1:0] ENV_OFF     = 3'd0;
  localparam logic [ENV_W-1:0] ENV_ATTACK  = 3'd1;
  localparam logic [ENV_W-1:0] ENV_DECAY   = 3'd2;
  localparam logic [ENV_W-1:0] ENV_SUSTAIN = 3'd3;
  localparam logic [ENV_W-1:0] ENV_RELEASE = 3'd4;

  localparam logic [15:0] VOL_MAX  = 16'd52429;
  localparam logic [16:0] OUT_GAIN = 17'd52429;
  localparam logic signed [15:0] CLIP_OUT = 16'sd21822;

  function automatic logic [15:0] atk_rate(input logic [MODE_W-1:0] m);
    case (m)
      MODE_EPIANO:  atk_rate = 16'd3277;
      MODE_STRINGS: atk_rate = 16'd131;
      default:      atk_rate = 16'd6554;
    endcase
  endfunction

  function automatic logic [15:0] dec_rate(input logic [MODE_W-1:0] m);
    case (m)
      MODE_EPIANO:  dec_rate = 16'd131;
      MODE_STRINGS: dec_rate = 16'd66;
      default:      dec_rate = 16'd328;
    endcase
  endfunction

  function automatic logic [15:0] sus_frac(input logic [MODE_W-1:0] m);
    case (m)
      MODE_EPIANO:  sus_frac = 16'd39322;
      MODE_STRINGS: sus_frac = 16'd58982;
      default:      sus_frac = 16'd19661;
    endcase
  endfunction

  function automatic logic [15:0] rel_rate(input logic [MODE_W-1:0] m);
    case (m)
      MODE_EPIANO:  rel_rate = 16'd328;
      MODE_STRINGS: rel_rate = 16'd131;
      default:      rel_rate = 16'd655;
    endcase
  endfunction

  // harmonic weights, Q0.16, for the three wave lookups of a voice
  function automatic logic [15:0] wave_coef(input logic [MODE_W-1:0] m,
                                            input logic [1:0] term);
    wave_coef = 16'd0;
    case (m)
      MODE_EPIANO: begin
        if (term == 2'd0) wave_coef = 16'd52429;
        else if (term == 2'd1) wave_coef = 16'd13107;
      end
      MODE_STRINGS: begin
        if (term == 2'd0) wave_coef = 16'd26214;
      end
      default: begin
        if (term == 2'd0) wave_coef = 16'd45875;
        else if (term == 2'd1) wave_coef = 16'd13107;
        else if (term == 2'd2) wave_coef = 16'd6554;
      end
    endcase
  endfunction

  function automatic longint unsigned semitone(input int k);
    case (k)
      1:       semitone = 69433;
      2:       semitone = 73562;
      3:       semitone = 77936;
      4:       semitone = 82570;
      5:       semitone = 87480;
      6:       semitone = 92682;
      7:       semitone = 98193;
      8:       semitone = 104033;
      9:       semitone = 110218;
      10:      semitone = 116772;
      11:      semitone = 123715;
      default: semitone = 65536;
    endcase
  endfunction

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_NOTE_ON, OP_NOTE_OFF, OP_W0, OP_W1, OP_W2, OP_SUS,
    OP_ENV, OP_MAC, OP_SKIP, OP_SC_LO, OP_SC_HI, OP_SQ, OP_CUBE, OP_T
  } op_t;

  typedef enum logic [1:0] {SCL_INV, SCL_VOL, SCL_GAIN} scl_t;

  typedef struct packed {
    op_t  op;
    scl_t scl;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cur_on;
    logic last;
    logic multi;
  } sts_t;

endpackage

// ===== src/psyn_if.sv =====
// Handshake channel interfaces: note/tick events, PCM samples, register writes.
interface psyn_event_if
  import psyn_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [NOTE_W-1:0]   note;
  logic [VEL_W-1:0]    velocity;
  modport source (output valid, action, note, velocity, input ready);
  modport sink (input valid, action, note, velocity, output ready);
endinterface

interface psyn_sample_if
  import psyn_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [COUNT_OUT_W-1:0]     voices_active;
  modport source (output valid, sample, voices_active, input ready);
  modport sink (input valid, sample, voices_active, output ready);
endinterface

interface psyn_cfg_if
  import psyn_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/psyn_ctrl.sv =====
// Sequencer for events and for the per-voice walk and output chain of a tick.
module psyn_ctrl
  import psyn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [ACTION_W-1:0] in_action,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sts_t                sts,
  output cmd_t                cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_NOTE_ON, ST_NOTE_OFF, ST_W0, ST_W1, ST_W2, ST_SUS, ST_ENV, ST_MAC,
    ST_INV_LO, ST_INV_HI, ST_VOL_LO, ST_VOL_HI, ST_GAIN_LO, ST_GAIN_HI,
    ST_SQ, ST_CUBE, ST_T, ST_Y
  } state_t;

  state_t state, state_next;
  logic   scale_first;

  assign in_ready = (state == ST_IDLE);
  assign scale_first = sts.multi;

  always_comb begin
    cmd = '{op: OP_NONE, scl: SCL_VOL, out_load: 1'b0};
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LATCH;
          if (in_action == ACT_NOTE_ON) state_next = ST_NOTE_ON;
          else if (in_action == ACT_NOTE_OFF) state_next = ST_NOTE_OFF;
          else if (in_action == ACT_TICK) state_next = ST_W0;
        end
      end
      ST_NOTE_ON: begin
        cmd.op = OP_NOTE_ON;
        state_next = ST_IDLE;
      end
      ST_NOTE_OFF: begin
        cmd.op = OP_NOTE_OFF;
        state_next = ST_IDLE;
      end
      ST_W0: begin
        if (sts.cur_on) begin
          cmd.op = OP_W0;
          state_next = ST_W1;
        end else begin
          cmd.op = OP_SKIP;
          if (sts.last) state_next = scale_first ? ST_INV_LO : ST_VOL_LO;
        end
      end
      ST_W1: begin
        cmd.op = OP_W1;
        state_next = ST_W2;
      end
      ST_W2: begin
        cmd.op = OP_W2;
        state_next = ST_SUS;
      end
      ST_SUS: begin
        cmd.op = OP_SUS;
        state_next = ST_ENV;
      end
      ST_ENV: begin
        cmd.op = OP_ENV;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        cmd.op = OP_MAC;
        if (sts.last) state_next = scale_first ? ST_INV_LO : ST_VOL_LO;
        else state_next = ST_W0;
      end
      ST_INV_LO: begin
        cmd.op = OP_SC_LO; cmd.scl = SCL_INV; state_next = ST_INV_HI;
      end
      ST_INV_HI: begin
        cmd.op = OP_SC_HI; cmd.scl = SCL_INV; state_next = ST_VOL_LO;
      end
      ST_VOL_LO: begin
        cmd.op = OP_SC_LO; cmd.scl = SCL_VOL; state_next = ST_VOL_HI;
      end
      ST_VOL_HI: begin
        cmd.op = OP_SC_HI; cmd.scl = SCL_VOL; state_next = ST_GAIN_LO;
      end
      ST_GAIN_LO: begin
        cmd.op = OP_SC_LO; cmd.scl = SCL_GAIN; state_next = ST_GAIN_HI;
      end
      ST_GAIN_HI: begin
        cmd.op = OP_SC_HI; cmd.scl = SCL_GAIN; state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.op = OP_SQ; state_next = ST_CUBE;
      end
      ST_CUBE: begin
        cmd.op = OP_CUBE; state_next = ST_T;
      end
      ST_T: begin
        cmd.op = OP_T; state_next = ST_Y;
      end
      ST_Y: begin
        // wait here until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/psyn_dp.sv =====
// Voice state, wave tables, envelope, mixer, scaling and soft clip datapath.
module psyn_dp
  import psyn_pkg::*;
#(
  parameter int VOICES      = VOICES_DEF,
  parameter int WAVE_POINTS = WAVE_POINTS_DEF,
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic [NOTE_W-1:0]          in_note,
  input  logic [VEL_W-1:0]           in_velocity,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic [COUNT_OUT_W-1:0]     out_count
);

  localparam int PA_W    = $clog2(WAVE_POINTS);
  localparam int PH_W    = PA_W + 16;
  localparam int VI_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W   = $clog2(VOICES + 1);
  localparam int MIX_W   = 33 + $clog2(VOICES);
  localparam int PROD_W  = MIX_W + 18;
  localparam int NOTES   = 1 << NOTE_W;
  localparam longint unsigned WRAP = longint'(WAVE_POINTS) << 16;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned STEP_DEN = longint'(SAMPLE_RATE) * 64;
  localparam longint unsigned STEP_HALF = STEP_DEN >> 1;
  localparam logic signed [MIX_W-1:0] LIM = MIX_W'(64'h8000_0000);

  typedef logic [WAVE_POINTS-1:0][15:0] sine_tab_t;
  typedef logic [NOTES-1:0][PH_W-1:0]   step_tab_t;
  typedef logic [VOICES:0][16:0]        inv_tab_t;

  function automatic sine_tab_t make_sine();
    sine_tab_t t;
    longint unsigned u, r, th, x2, s, v, q15, q;
    for (int i = 0; i < WAVE_POINTS; i++) begin
      u = (64'(i) << 32) / WAVE_POINTS;
      q = (u >> 30) & 64'd3;
      r = u & (Q30_ONE - 64'd1);
      if (q[0]) r = Q30_ONE - r;
      th = (r * HALF_PI_Q30) >> 30;
      x2 = (th * th) >> 30;
      s = Q30_ONE - x2 / 110;
      s = Q30_ONE - ((x2 * s) >> 30) / 72;
      s = Q30_ONE - ((x2 * s) >> 30) / 42;
      s = Q30_ONE - ((x2 * s) >> 30) / 20;
      s = Q30_ONE - ((x2 * s) >> 30) / 6;
      v = (th * s) >> 30;
      q15 = (v + 64'd16384) >> 15;
      if (q15 > 64'd32767) q15 = 64'd32767;
      t[i] = (q >= 64'd2) ? 16'(-q15) : q15[15:0];
    end
    return t;
  endfunction

  function automatic step_tab_t make_steps();
    step_tab_t t;
    longint unsigned num, st;
    int d;
    for (int n = 0; n < NOTES; n++) begin
      d = n + 3;
      num = (64'd440 * semitone(d % 12) * 64'(WAVE_POINTS)) << (d / 12);
      st = (num + STEP_HALF) / STEP_DEN;
      st = st % WRAP;
      t[n] = st[PH_W-1:0];
    end
    return t;
  endfunction

  // 1/sqrt(n) in Q1.16: largest r with r*r*n <= 2^32
  function automatic inv_tab_t make_inv();
    inv_tab_t t;
    longint unsigned lo, hi, mid;
    t[0] = 17'd65536;
    for (int i = 1; i <= VOICES; i++) begin
      lo = 64'd0;
      hi = 64'd65537;
      while (hi - lo > 64'd1) begin
        mid = (lo + hi) >> 1;
        if (mid * mid * 64'(i) <= (64'd1 << 32)) lo = mid;
        else hi = mid;
      end
      t[i] = lo[16:0];
    end
    return t;
  endfunction

  localparam sine_tab_t SINE = make_sine();
  localparam step_tab_t STEP = make_steps();
  localparam inv_tab_t  INV  = make_inv();

  // reduce a small multiple of a table index back into the table
  function automatic logic [PA_W-1:0] wrap_idx(input logic [PA_W+2:0] val);
    logic [PA_W+2:0] x;
    x = val;
    for (int k = 0; k < 3; k++)
      if (x >= (PA_W+3)'(WAVE_POINTS)) x = x - (PA_W+3)'(WAVE_POINTS);
    return x[PA_W-1:0];
  endfunction

  // configuration
  logic [MODE_W-1:0] engine_mode;
  logic [15:0]       out_vol;
  logic [MODE_W-1:0] mode;

  // voice state
  logic [NOTE_W-1:0] v_note   [VOICES];
  logic [PH_W-1:0]   v_phase  [VOICES];
  logic [PH_W-1:0]   v_step   [VOICES];
  logic [15:0]       v_level  [VOICES];
  logic [15:0]       v_target [VOICES];
  logic [ENV_W-1:0]  v_env    [VOICES];
  logic              v_on     [VOICES];

  // working registers
  logic [NOTE_W-1:0]        lat_note;
  logic [VEL_W-1:0]         lat_vel;
  logic [VI_W-1:0]          vi;
  logic [CNT_W-1:0]         count;
  logic signed [33:0]       acc;
  logic [15:0]              sus;
  logic [15:0]              lvl;
  logic signed [MIX_W-1:0]  mix;
  logic signed [PROD_W-1:0] prod;
  logic signed [15:0]       x15;
  logic                     clip_pos, clip_neg;
  logic signed [31:0]       sq;
  logic signed [47:0]       cube;
  logic signed [17:0]       tcub;

  // per-voice combinational path
  logic [PH_W-1:0]        cur_phase;
  logic [PA_W-1:0]        ph, idx1, idx2, idx3;
  logic signed [16:0]     saw;
  logic signed [15:0]     wv_a, wv_b, wv_c;
  logic signed [16:0]     coef0, coef1, coef2, saw_coef;
  logic signed [33:0]     term0, term1, term2;
  logic signed [17:0]     lvl_new;
  logic signed [17:0]     cur_lvl, cur_tgt;
  logic [ENV_W-1:0]       env_new;
  logic                   on_new;
  logic [PH_W:0]          ph_sum;
  logic [PH_W-1:0]        ph_new;
  logic [31:0]            sus_p;
  logic signed [MIX_W-1:0] mac_p;
  logic signed [15:0]     s_cur;
  logic signed [16:0]     lvl_s;

  // scaling path
  logic [16:0]              m;
  logic signed [17:0]       m_s;
  logic [34:0]              lo_p;
  logic signed [MIX_W-19:0] mix_hi;
  logic signed [PROD_W-1:0] hi_p, sc_sum, sc_sh;

  // clip path
  logic signed [15:0] x_hi;
  logic signed [31:0] sq_w;
  logic signed [47:0] cube_w;
  logic signed [17:0] c18;
  logic signed [33:0] t_w;
  logic signed [17:0] y18;
  logic signed [33:0] yp;
  logic signed [15:0] res;

  // note-on search
  logic              free_found;
  logic [VI_W-1:0]   free_idx;

  assign mode = (engine_mode == MODE_PIANO || engine_mode == MODE_EPIANO ||
                 engine_mode == MODE_STRINGS) ? engine_mode : MODE_PIANO;

  assign sts.cur_on = v_on[vi];
  assign sts.last   = (vi == VI_W'(VOICES - 1));
  assign sts.multi  = (count > CNT_W'(1));

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (!free_found && (!v_on[v] || v_env[v] == ENV_OFF)) begin
        free_found = 1'b1;
        free_idx = VI_W'(v);
      end
    end
  end

  // wave lookup; the integer part of the phase is always inside the table
  assign cur_phase = v_phase[vi];
  assign ph   = cur_phase[PH_W-1:16];
  assign idx1 = ph;
  assign idx2 = (mode == MODE_EPIANO) ? wrap_idx((PA_W+3)'({ph, 2'b00}))
                                      : wrap_idx((PA_W+3)'({ph, 1'b0}));
  assign idx3 = wrap_idx((PA_W+3)'(ph) + (PA_W+3)'({ph, 1'b0}));
  assign saw  = $signed({1'b0, cur_phase[PH_W-1:PA_W]}) - 17'sd32768;
  assign wv_a = $signed(SINE[idx1]);
  assign wv_b = $signed(SINE[idx2]);
  assign wv_c = $signed(SINE[idx3]);
  assign coef0 = $signed({1'b0, wave_coef(mode, 2'd0)});
  assign coef1 = $signed({1'b0, wave_coef(mode, 2'd1)});
  assign coef2 = $signed({1'b0, wave_coef(mode, 2'd2)});
  assign saw_coef = coef0;
  assign term0 = (mode == MODE_STRINGS) ? saw * saw_coef : wv_a * coef0;
  assign term1 = wv_b * coef1;
  assign term2 = wv_c * coef2;

  // envelope step
  assign sus_p = v_target[vi] * sus_frac(mode);
  assign cur_lvl = $signed({2'b00, v_level[vi]});
  assign cur_tgt = $signed({2'b00, v_target[vi]});

  always_comb begin
    lvl_new = cur_lvl;
    env_new = v_env[vi];
    on_new  = v_on[vi];
    case (v_env[vi])
      ENV_ATTACK: begin
        lvl_new = cur_lvl + $signed({2'b00, atk_rate(mode)});
        if (lvl_new >= cur_tgt) begin
          lvl_new = cur_tgt;
          env_new = ENV_DECAY;
        end
      end
      ENV_DECAY: begin
        lvl_new = cur_lvl - $signed({2'b00, dec_rate(mode)});
        if (lvl_new <= $signed({2'b00, sus})) begin
          lvl_new = $signed({2'b00, sus});
          env_new = ENV_SUSTAIN;
        end
      end
      ENV_RELEASE: begin
        lvl_new = cur_lvl - $signed({2'b00, rel_rate(mode)});
        if (lvl_new <= 18'sd0) begin
          lvl_new = '0;
          env_new = ENV_OFF;
          on_new  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign ph_sum = {1'b0, cur_phase} + {1'b0, v_step[vi]};
  assign ph_new = (ph_sum >= (PH_W+1)'(WRAP)) ? PH_W'(ph_sum - (PH_W+1)'(WRAP))
                                               : ph_sum[PH_W-1:0];

  assign s_cur = acc[31:16];
  assign lvl_s = $signed({1'b0, lvl});
  assign mac_p = s_cur * lvl_s;

  // mix scaling in two partial products
  always_comb begin
    case (cmd.scl)
      SCL_INV: m = INV[count];
      SCL_VOL: m = {1'b0, out_vol};
      default: m = OUT_GAIN;
    endcase
  end
  assign m_s    = $signed({1'b0, m});
  assign lo_p   = mix[17:0] * m;
  assign mix_hi = mix[MIX_W-1:18];
  assign hi_p   = mix_hi * m_s;
  assign sc_sum = prod + (hi_p <<< 18);
  assign sc_sh  = sc_sum >>> 16;

  // cubic soft clip: square, cube, scaled cube, one product a cycle, then output
  assign x_hi   = mix[31:16];
  assign sq_w   = x_hi * x_hi;
  assign cube_w = sq * x15;
  assign c18    = cube[47:30];
  assign t_w    = c18 * 17'sd21845;
  assign y18    = 18'(x15) - tcub;
  assign yp     = y18 * 17'sd32767;
  assign res    = clip_pos ? CLIP_OUT : (clip_neg ? -CLIP_OUT : yp[30:15]);

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_mode <= MODE_PIANO;
      out_vol <= VOL_MAX;
      for (int v = 0; v < VOICES; v++) begin
        v_note[v] <= '0; v_phase[v] <= '0; v_step[v] <= '0; v_level[v] <= '0;
        v_target[v] <= '0; v_env[v] <= ENV_OFF; v_on[v] <= 1'b0;
      end
      vi <= '0;
      count <= '0;
      mix <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MODE) engine_mode <= cfg_data[MODE_W-1:0];
        else if (cfg_index == REG_VOLUME)
          out_vol <= (cfg_data > VOL_MAX) ? VOL_MAX : cfg_data;
      end
      case (cmd.op)
        OP_LATCH: begin
          lat_note <= in_note;
          lat_vel <= in_velocity;
          vi <= '0;
          count <= '0;
          mix <= '0;
        end
        OP_NOTE_ON: begin
          if (free_found) begin
            v_note[free_idx] <= lat_note;
            v_step[free_idx] <= STEP[lat_note];
            v_phase[free_idx] <= '0;
            v_level[free_idx] <= '0;
            v_target[free_idx] <= lat_vel;
            v_env[free_idx] <= ENV_ATTACK;
            v_on[free_idx] <= 1'b1;
          end
        end
        OP_NOTE_OFF: begin
          for (int v = 0; v < VOICES; v++)
            if (v_on[v] && v_note[v] == lat_note) v_env[v] <= ENV_RELEASE;
        end
        OP_W0: begin
          count <= count + CNT_W'(1);
          acc <= term0;
        end
        OP_W1: acc <= acc + term1;
        OP_W2: acc <= acc + term2;
        OP_SUS: sus <= sus_p[31:16];
        OP_ENV: begin
          v_level[vi] <= lvl_new[15:0];
          v_env[vi] <= env_new;
          v_on[vi] <= on_new;
          v_phase[vi] <= ph_new;
          lvl <= lvl_new[15:0];
        end
        OP_MAC: begin
          mix <= mix + mac_p;
          vi <= sts.last ? '0 : vi + VI_W'(1);
        end
        OP_SKIP: vi <= sts.last ? '0 : vi + VI_W'(1);
        OP_SC_LO: prod <= $signed({{(PROD_W-35){1'b0}}, lo_p});
        OP_SC_HI: mix <= sc_sh[MIX_W-1:0];
        OP_SQ: begin
          clip_pos <= (mix >= LIM);
          clip_neg <= (mix <= -LIM);
          x15 <= x_hi;
          sq <= sq_w;
        end
        OP_CUBE: cube <= cube_w;
        OP_T: tcub <= t_w[33:16];
        default: ;
      endcase
      if (cmd.out_load) begin
        out_sample <= res;
        out_count <= COUNT_OUT_W'(count);
      end
    end
  end

endmodule

// ===== src/polyphonic_adsr_synth_core.sv =====
// Top level of the polyphonic ADSR wavetable synthesizer core.
//
//  channel   dir   handshake      payload
//  events    in    valid/ready    action, note, velocity
//  samples   out   valid/ready    sample, voices_active
//  cfg       in    valid/ready    index, data (0 engine_mode, 1 volume)
//
// After a note on or note off is taken, the core applies it in a state of its own, then takes the next word.
// A tick walks every voice in turn through one shared envelope, wave and
// multiply path (a silent voice is only skipped), then scales the mix (the
// 1/sqrt(n) step is skipped when fewer than two voices sound) and soft-clips it.
// Reset (rst, synchronous) silences all voices and restores the registers.
// A finished sample waits in the output register; the core only stalls when
// the next sample is ready while the previous one has not been taken.
module polyphonic_adsr_synth_core
  import psyn_pkg::*;
#(
  parameter int VOICES      = VOICES_DEF,
  parameter int WAVE_POINTS = WAVE_POINTS_DEF,
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
  input logic           clk,
  input logic           rst,
  psyn_event_if.sink    events,
  psyn_sample_if.source samples,
  psyn_cfg_if.sink      cfg
);

  cmd_t cmd;
  sts_t sts;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  psyn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (events.valid),
    .in_action (events.action),
    .in_ready  (events.ready),
    .out_valid (samples.valid),
    .out_ready (samples.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  psyn_dp #(
    .VOICES      (VOICES),
    .WAVE_POINTS (WAVE_POINTS),
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_note     (events.note),
    .in_velocity (events.velocity),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .out_sample  (samples.sample),
    .out_count   (samples.voices_active)
  );

endmodule

// ===== verif/psyn_checker.sv =====
// Scoreboard for the synth core: watches the channels, predicts PCM words, compares.
module psyn_checker
  import psyn_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  psyn_event_if  evt,
  psyn_sample_if smp,
  psyn_cfg_if    cfg,
  output int     errors,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q30 = 64'd1073741824;
  localparam longint HALF_PI = 64'd1686629713;

  typedef struct {
    logic signed [SAMPLE_W-1:0] pcm;
    logic [COUNT_OUT_W-1:0]     cnt;
  } pcm_word_t;

  pcm_word_t pcm_due[$];

  longint semi_q16[12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                           92682, 98193, 104033, 110218, 116772, 123715};
  longint attack_by_mode[3]  = '{6554, 3277, 131};
  longint decay_by_mode[3]   = '{328, 131, 66};
  longint sus_by_mode[3]     = '{19661, 39322, 58982};
  longint release_by_mode[3] = '{655, 328, 131};

  logic [MODE_W-1:0] mode_q;
  logic [15:0]       vol_q;
  logic [NOTE_W-1:0] v_note[VOICES_DEF];
  logic [23:0]       v_phase[VOICES_DEF];
  logic [23:0]       v_step[VOICES_DEF];
  logic [15:0]       v_level[VOICES_DEF];
  logic [15:0]       v_target[VOICES_DEF];
  logic [ENV_W-1:0]  v_env[VOICES_DEF];
  logic              v_on[VOICES_DEF];
  longint            sine_tab[WAVE_POINTS_DEF];
  longint            inv_sqrt_tab[VOICES_DEF+1];

  function automatic longint sine_at(int i);
    longint u, r, th, x2, s, v, q15;
    int q;
    u = (longint'(i) << 32) / WAVE_POINTS_DEF;
    q = int'((u >> 30) & 3);
    r = u & (Q30 - 1);
    if (q & 1) r = Q30 - r;
    th = (r * HALF_PI) >> 30;
    x2 = (th * th) >> 30;
    s = Q30 - x2 / 110;
    s = Q30 - ((x2 * s) >> 30) / 72;
    s = Q30 - ((x2 * s) >> 30) / 42;
    s = Q30 - ((x2 * s) >> 30) / 20;
    s = Q30 - ((x2 * s) >> 30) / 6;
    v = (th * s) >> 30;
    q15 = (v + (1 << 14)) >> 15;
    if (q15 > 32767) q15 = 32767;
    return (q >= 2) ? -q15 : q15;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [23:0] note_inc(logic [NOTE_W-1:0] n);
    longint d, num, den;
    d = longint'(n) + 3;
    num = (64'd440 * semi_q16[d % 12] * WAVE_POINTS_DEF) << (d / 12);
    den = longint'(SAMPLE_RATE_DEF) * 64;
    return 24'((num + den / 2) / den);
  endfunction

  function automatic longint wave_at(int m, logic [23:0] phase);
    longint ph, acc;
    ph = longint'(phase >> 16);
    if (m == 2) return ((longint'(phase) / WAVE_POINTS_DEF - 32768) * 26214) >>> 16;
    if (m == 1)
      acc = sine_tab[ph] * 52429 + sine_tab[(ph * 4) % WAVE_POINTS_DEF] * 13107;
    else
      acc = sine_tab[ph] * 45875 + sine_tab[(ph * 2) % WAVE_POINTS_DEF] * 13107
          + sine_tab[(ph * 3) % WAVE_POINTS_DEF] * 6554;
    return acc >>> 16;
  endfunction

  // one tick over all voices; returns the PCM word it makes
  function automatic pcm_word_t run_tick();
    pcm_word_t w;
    int m, cnt;
    longint s, lvl, tgt, sus, mix, x15, y;
    m = (mode_q == 2'd3) ? 0 : int'(mode_q);
    cnt = 0;
    mix = 0;
    for (int v = 0; v < VOICES_DEF; v++) begin
      if (!v_on[v]) continue;
      cnt++;
      s = wave_at(m, v_phase[v]);
      lvl = longint'(v_level[v]);
      tgt = longint'(v_target[v]);
      if (v_env[v] == ENV_ATTACK) begin
        lvl += attack_by_mode[m];
        if (lvl >= tgt) begin
          lvl = tgt;
          v_env[v] = ENV_DECAY;
        end
      end else if (v_env[v] == ENV_DECAY) begin
        sus = (tgt * sus_by_mode[m]) >> 16;
        lvl -= decay_by_mode[m];
        if (lvl <= sus) begin
          lvl = sus;
          v_env[v] = ENV_SUSTAIN;
        end
      end else if (v_env[v] == ENV_RELEASE) begin
        lvl -= release_by_mode[m];
        if (lvl <= 0) begin
          lvl = 0;
          v_env[v] = ENV_OFF;
          v_on[v] = 1'b0;
        end
      end
      v_level[v] = 16'(lvl);
      mix += s * lvl;
      v_phase[v] = v_phase[v] + v_step[v];  // 24-bit wrap = 256 points
    end
    if (cnt > 1) mix = (mix * inv_sqrt_tab[cnt]) >>> 16;
    mix = (mix * longint'(vol_q)) >>> 16;
    mix = (mix * 52429) >>> 16;
    if (mix >= 64'sd2147483648) w.pcm = CLIP_OUT;
    else if (mix <= -64'sd2147483648) w.pcm = -CLIP_OUT;
    else begin
      x15 = mix >>> 16;
      y = x15 - ((((x15 * x15 * x15) >>> 30) * 21845) >>> 16);
      w.pcm = 16'((y * 32767) >>> 15);
    end
    w.cnt = 4'(cnt);
    return w;
  endfunction

  initial begin
    for (int i = 0; i < WAVE_POINTS_DEF; i++) sine_tab[i] = sine_at(i);
    inv_sqrt_tab[0] = 65536;
    for (int i = 1; i <= VOICES_DEF; i++) inv_sqrt_tab[i] = int_sqrt(64'd4294967296 / i);
  end

  assign pending = pcm_due.size();

  always @(posedge clk) begin
    pcm_word_t w;
    int bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
      mode_q = MODE_PIANO;
      vol_q = VOL_MAX;
      pcm_due.delete();
      for (int v = 0; v < VOICES_DEF; v++) begin
        v_note[v] = '0; v_phase[v] = '0; v_step[v] = '0; v_level[v] = '0;
        v_target[v] = '0; v_env[v] = ENV_OFF; v_on[v] = 1'b0;
      end
    end else begin
      // compare first: a new tick can't finish in the cycle it is taken
      if (smp.valid && smp.ready) begin
        if (pcm_due.size() == 0) begin
          $error("unexpected PCM word: sample %0d voices_active %0d",
                 smp.sample, smp.voices_active);
          bad++;
        end else begin
          w = pcm_due.pop_front();
          if (smp.sample !== w.pcm) begin
            $error("sample: expected %0d, actual %0d", w.pcm, smp.sample);
            bad++;
          end
          if (smp.voices_active !== w.cnt) begin
            $error("voices_active: expected %0d, actual %0d", w.cnt, smp.voices_active);
            bad++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MODE) mode_q = cfg.data[MODE_W-1:0];
        else if (cfg.index == REG_VOLUME) vol_q = (cfg.data > VOL_MAX) ? VOL_MAX : cfg.data;
      end
      if (evt.valid && evt.ready) begin
        case (evt.action)
          ACT_NOTE_ON: begin
            for (int v = 0; v < VOICES_DEF; v++) begin
              if (!v_on[v] || v_env[v] == ENV_OFF) begin
                v_note[v] = evt.note;
                v_step[v] = note_inc(evt.note);
                v_phase[v] = '0;
                v_level[v] = '0;
                v_target[v] = evt.velocity;
                v_env[v] = ENV_ATTACK;
                v_on[v] = 1'b1;
                break;
              end
            end
          end
          ACT_NOTE_OFF: begin
            for (int v = 0; v < VOICES_DEF; v++)
              if (v_on[v] && v_note[v] == evt.note) v_env[v] = ENV_RELEASE;
          end
          ACT_TICK: pcm_due.push_back(run_tick());
          default: ;  // unused action code: nothing
        endcase
      end
      errors <= errors + bad;
    end
  end
endmodule

// ===== verif/tb_top.sv =====
// Testbench top: drives events, register writes and PCM back-pressure; gives the verdict.
module tb_top;
  import psyn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   burst_left = 0;
  int   words_sent = 0, ticks_sent = 0, cfg_writes = 0;
  logic [NOTE_W-1:0] held[$];  // notes recently started, so note-offs hit

  psyn_event_if  ev_if();
  psyn_sample_if pcm_if();
  psyn_cfg_if    cfg_if();

  polyphonic_adsr_synth_core u_top (
    .clk(clk), .rst(rst), .events(ev_if), .samples(pcm_if), .cfg(cfg_if)
  );

  psyn_checker u_chk (
    .clk(clk), .rst(rst), .evt(ev_if), .smp(pcm_if), .cfg(cfg_if),
    .errors(errors), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4ms;
    $display("polyphonic_adsr_synth_core: mismatch");
    $finish;
  end

  // PCM receiver: rotates between always-ready, coin-flip and long stalls
  int rx_cyc = 0, rx_hold = 0;
  always @(negedge clk) begin
    rx_cyc++;
    if (rst) pcm_if.ready = 1'b0;
    else case ((rx_cyc / 700) % 3)
      0: pcm_if.ready = 1'b1;
      1: pcm_if.ready = 1'($urandom_range(0, 1));
      default: begin
        if (rx_hold > 0) rx_hold--;
        else begin
          pcm_if.ready = !pcm_if.ready;
          rx_hold = pcm_if.ready ? $urandom_range(0, 5) : $urandom_range(1, 30);
        end
      end
    endcase
  end

  // one event word; sender runs in bursts separated by random gaps
  task automatic send_word(logic [ACTION_W-1:0] a, logic [NOTE_W-1:0] n,
                           logic [VEL_W-1:0] v);
    if (burst_left == 0) begin
      ev_if.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    ev_if.valid = 1'b1;
    ev_if.action = a;
    ev_if.note = n;
    ev_if.velocity = v;
    @(posedge clk);
    while (!ev_if.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
    if (a == ACT_TICK) ticks_sent++;
    if (a == ACT_NOTE_ON) begin
      held.push_back(n);
      if (held.size() > 12) void'(held.pop_front());
    end
  endtask

  // register write only with the core drained: no PCM word outstanding, then a settling wait
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    ev_if.valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    cfg_writes++;
  endtask

  // random word: mostly ticks and note traffic that recycles voices
  task automatic random_word();
    int pick;
    logic [NOTE_W-1:0] n;
    logic [VEL_W-1:0]  v;
    pick = $urandom_range(0, 99);
    n = 7'($urandom_range(0, 127));
    v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    if (pick < 55) send_word(ACT_TICK, n, v);
    else if (pick < 75) send_word(ACT_NOTE_ON, n, v);
    else if (pick < 93) begin
      if (held.size() > 0 && $urandom_range(0, 4) != 0)
        n = held[$urandom_range(0, held.size() - 1)];
      send_word(ACT_NOTE_OFF, n, v);
    end else send_word(ACT_RESERVED, n, v);
  endtask

  logic [15:0] vol_plan[4] = '{16'hFFFF, 16'd0, 16'd52429, 16'd30000};

  initial begin
    ev_if.valid = 1'b0;
    ev_if.action = ACT_TICK;
    ev_if.note = '0;
    ev_if.velocity = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MODE;
    cfg_if.data = '0;
    pcm_if.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: all voices on one note at full level to push the clipper,
    // a dropped ninth note-on, zero velocity, extreme notes, unused action
    write_reg(REG_MODE, 16'(MODE_PIANO));
    for (int i = 0; i < 8; i++) send_word(ACT_NOTE_ON, 7'd69, 16'hFFFF);
    send_word(ACT_NOTE_ON, 7'd127, 16'hFFFF);          // no free voice
    repeat (8) send_word(ACT_TICK, 7'd0, 16'd0);
    send_word(ACT_NOTE_OFF, 7'd69, 16'd0);
    send_word(ACT_RESERVED, 7'h7F, 16'hFFFF);          // ignored
    send_word(ACT_TICK, 7'd0, 16'd0);
    send_word(ACT_NOTE_ON, 7'd0, 16'd0);
    send_word(ACT_NOTE_ON, 7'd127, 16'h8000);
    repeat (3) send_word(ACT_TICK, 7'd0, 16'd0);

    // random phases across every mode (3 aliases piano) and volume extremes
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MODE, 16'(ph % 4));
      write_reg(REG_VOLUME, (ph < 4) ? vol_plan[ph] : 16'($urandom));
      for (int i = 0; i < 180; i++) begin
        random_word();
        if (ph == 2 && i == 90) begin
          // let the core drain completely mid-phase
          ev_if.valid = 1'b0;
          burst_left = 0;
          while (pending != 0) @(negedge clk);
        end
      end
    end

    ev_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("covered %0d event words (%0d ticks) and %0d register writes,",
             words_sent, ticks_sent, cfg_writes);
    $display("all four mode codes, volume zero to saturated, voice overflow and clipping");
    if (errors == 0) $display("polyphonic_adsr_synth_core: match");
    else $display("polyphonic_adsr_synth_core: mismatch");
    $finish;
  end
endmodule
